/* rtl/core/cspp_pkg.sv */
// Package for the capnograph sync packet parser: packet layout, sync codes,
// packet type codes and the constants of the fixed-point scaling.
// Depends on nothing; used by capnograph_sync_packet_parser_top.
package cspp_pkg;

    localparam int PACKET_BYTES = 20;
    localparam int CNT_W        = $clog2(PACKET_BYTES + 1);

    typedef logic [CNT_W-1:0] t_count;
    typedef logic [7:0]       t_byte;

    localparam t_byte SYNC_FIRST  = 8'hAA;
    localparam t_byte SYNC_SECOND = 8'h55;
    localparam t_byte RAW_INVALID = 8'd255;
    localparam t_byte STATUS_ADAPTER = 8'd16;
    localparam t_byte ZERO_RUNNING   = 8'd2;

    localparam t_count POS_KIND    = t_count'(1);
    localparam t_count POS_STATUS  = t_count'(2);
    localparam t_count POS_WAVE_HI = t_count'(3);
    localparam t_count POS_WAVE_LO = t_count'(4);
    localparam t_count POS_VALUE   = t_count'(13);
    localparam t_count POS_ZERO    = t_count'(15);
    localparam t_count POS_LAST    = t_count'(PACKET_BYTES);

    localparam t_byte KIND_INSPIRED = 8'd0;
    localparam t_byte KIND_ETCO2    = 8'd1;
    localparam t_byte KIND_RESP     = 8'd3;
    localparam t_byte KIND_ZEROING  = 8'd6;

    // Wave: word * 760 / 1000 = (word * 19) / 25, division by reciprocal.
    localparam int WAVE_P_W  = 21;
    localparam int WAVE_M_W  = 22;
    localparam int WAVE_SH   = 26;
    localparam logic [WAVE_M_W-1:0] WAVE_RECIP = 22'd2684355;
    localparam logic [4:0]          WAVE_MUL   = 5'd19;

    // CO2: byte * 760 / 100 = (byte * 38) / 5, division by reciprocal.
    localparam int CO2_P_W  = 14;
    localparam int CO2_M_W  = 15;
    localparam int CO2_SH   = 17;
    localparam logic [CO2_M_W-1:0] CO2_RECIP = 15'd26215;
    localparam logic [5:0]         CO2_MUL   = 6'd38;

endpackage

/* rtl/core/capnograph_sync_packet_parser_top.sv */
// Top level of the capnograph sync packet parser: sync search, byte capture,
// checksum, scaling and held output values. Depends on cspp_pkg.
// Output: o_valid and the held values are registered on the closing byte's transfer.
// Throughput: one byte per cycle; input stalls only while a result waits
// and the next byte would close another packet.
// Reset (synchronous, active low) clears the sync state and all held values.
module capnograph_sync_packet_parser_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  cspp_pkg::t_byte     i_rx_byte,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_packet_ok,
    output logic [15:0]         o_wave_mmhg,
    output logic [10:0]         o_etco2_mmhg,
    output logic [10:0]         o_inspired_mmhg,
    output logic [7:0]          o_resp_rate,
    output logic                o_zeroing_active,
    output logic                o_adapter_check
);
    import cspp_pkg::*;

    logic        r_saw_sync, n_saw_sync;
    logic        r_in_packet, n_in_packet;
    t_count      r_count, n_count;
    t_byte       r_sum, n_sum;
    t_byte       r_kind, r_wave_hi, r_value;
    logic        r_adapter, r_zero_req;
    logic [WAVE_P_W-1:0] r_wave_p;
    logic [15:0] r_wave_q;
    logic [CO2_P_W-1:0]  r_co2_p;
    logic [10:0] r_co2_q;
    logic        r_out_valid, n_out_valid;
    logic        r_out_ok, r_out_adapter;
    logic [15:0] r_wave_hold;
    logic [10:0] r_etco2_hold, r_insp_hold;
    t_byte       r_resp_hold;
    logic        r_zero_hold;

    logic        w_close_next, w_in_xfer, w_close, w_good, w_store;
    logic [WAVE_P_W+WAVE_M_W-1:0] w_wave_prod;
    logic [CO2_P_W+CO2_M_W-1:0]   w_co2_prod;

    assign w_close_next = r_in_packet && (r_count == POS_LAST);
    assign o_ready      = !r_out_valid || !w_close_next;
    assign w_in_xfer    = i_valid && o_ready;
    assign w_close      = w_in_xfer && w_close_next;
    assign w_store      = w_in_xfer && r_in_packet && !w_close_next;
    assign w_good       = (r_sum == 8'd0);

    assign w_wave_prod = WAVE_P_W'(r_wave_p) * WAVE_M_W'(WAVE_RECIP);
    assign w_co2_prod  = CO2_P_W'(r_co2_p) * CO2_M_W'(CO2_RECIP);

    always_comb begin
        n_saw_sync  = r_saw_sync;
        n_in_packet = r_in_packet;
        n_count     = r_count;
        n_sum       = r_sum;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_in_xfer) begin
            if (!r_in_packet) begin
                if (r_saw_sync) begin
                    n_saw_sync = 1'b0;
                    if (i_rx_byte == SYNC_SECOND) begin
                        n_in_packet = 1'b1;
                        n_count     = t_count'(1);
                        n_sum       = 8'd0;
                    end
                end else if (i_rx_byte == SYNC_FIRST) begin
                    n_saw_sync = 1'b1;
                end
            end else if (w_close_next) begin
                n_in_packet = 1'b0;
                n_count     = '0;
                n_sum       = 8'd0;
                n_out_valid = 1'b1;
            end else begin
                n_sum   = r_sum + i_rx_byte;
                n_count = r_count + t_count'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_saw_sync  <= 1'b0;
            r_in_packet <= 1'b0;
            r_count     <= '0;
            r_sum       <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_saw_sync  <= n_saw_sync;
            r_in_packet <= n_in_packet;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    // Capture of the packet bytes that the decode uses, and the scaled values.
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            case (r_count)
                POS_KIND:    r_kind <= i_rx_byte;
                POS_STATUS:  r_adapter <= (i_rx_byte == STATUS_ADAPTER);
                POS_WAVE_HI: r_wave_hi <= i_rx_byte;
                POS_WAVE_LO: r_wave_p <= WAVE_P_W'({r_wave_hi, i_rx_byte}) *
                                         WAVE_P_W'(WAVE_MUL);
                POS_VALUE: begin
                    r_value <= i_rx_byte;
                    r_co2_p <= CO2_P_W'(i_rx_byte) * CO2_P_W'(CO2_MUL);
                end
                POS_ZERO:    r_zero_req <= (i_rx_byte == ZERO_RUNNING);
                default:     ;
            endcase
        end
        r_wave_q <= w_wave_prod[WAVE_SH +: 16];
        r_co2_q  <= w_co2_prod[CO2_SH +: 11];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_hold   <= 16'd0;
            r_etco2_hold  <= 11'd0;
            r_insp_hold   <= 11'd0;
            r_resp_hold   <= 8'd0;
            r_zero_hold   <= 1'b0;
            r_out_ok      <= 1'b0;
            r_out_adapter <= 1'b0;
        end else if (w_close) begin
            r_out_ok      <= w_good;
            r_out_adapter <= w_good && r_adapter;
            if (w_good) begin
                r_wave_hold <= r_wave_q;
                case (r_kind)
                    KIND_INSPIRED: r_insp_hold <= r_co2_q;
                    KIND_ETCO2: begin
                        if (r_adapter || (r_value == RAW_INVALID)) begin
                            r_etco2_hold <= 11'd0;
                        end else begin
                            r_etco2_hold <= r_co2_q;
                        end
                    end
                    KIND_RESP: begin
                        r_resp_hold <= (r_value == RAW_INVALID) ? 8'd0 : r_value;
                    end
                    KIND_ZEROING:  r_zero_hold <= r_zero_req;
                    default:       ;
                endcase
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_packet_ok      = r_out_ok;
    assign o_wave_mmhg      = r_wave_hold;
    assign o_etco2_mmhg     = r_etco2_hold;
    assign o_inspired_mmhg  = r_insp_hold;
    assign o_resp_rate      = r_resp_hold;
    assign o_zeroing_active = r_zero_hold;
    assign o_adapter_check  = r_out_adapter;

endmodule
